### rtl/core/first_fit_block_allocator_core_defines.svh
// assertion macros used by the allocator core
// each macro expects clk and rst_n in the scope where it is used
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// condition holds at every clock edge outside reset
`define FFBA_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// condition in one cycle implies a condition in the next
`define FFBA_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define FFBA_ASSERT(lbl, cond, msg)
`define FFBA_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

### rtl/core/ffba_pkg.sv
`timescale 1ns / 1ps

package ffba_pkg;

    // field widths
    localparam int ADDR_W       = 20;
    localparam int SIZE_W       = 21;
    localparam int RND_W        = 22;

    // arena layout constants
    localparam int HEADER_BYTES = 12;
    localparam int ALIGN_BYTES  = 16;
    localparam int ARENA_MIN    = 64;
    localparam int ARENA_MAX    = 1048576;

    // one table entry
    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] payload;
        logic              is_free;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [0:0] {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        ST_DONE    = 3'd0,
        ST_ZERO    = 3'd1,
        ST_NOFIT   = 3'd2,
        ST_UNKNOWN = 3'd3,
        ST_NULL    = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_SPLIT,
        S_GRANT,
        S_COMPACT,
        S_CEND,
        S_RESP
    } state_t;

endpackage

### rtl/core/first_fit_block_allocator_core.sv
`timescale 1ns / 1ps
// First-fit block allocator. The arena is kept as an address-ordered table of
// blocks in a single RAM (one read and one write per cycle). An allocate
// rounds its size up to 16 bytes and walks the table for the first free block
// that fits, splitting it when enough is left over; a free looks up the block
// by its payload offset and then rewrites the whole table once, merging runs
// of free blocks. Each request is one transaction in and one out; the block
// takes one request at a time. An allocate walks the table RAM up to the hit and,
// for a split, moves the entries above it up by one; a free walks the table once
// to find the block and once more to compact it. The result waits in an output
// register while the next request is taken. A write on the cfg port sets the
// arena size and resets the table, as reset does.

`include "first_fit_block_allocator_core_defines.svh"

module first_fit_block_allocator_core
    import ffba_pkg::*;
#(
    parameter int MAX_BLOCKS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // request: tdata = request_bytes[20:0], payload_offset[40:21]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,
    // tuser = cmd[0]
    input  logic [0:0]  s_tuser,
    // result: tdata = granted_offset[19:0], free_total[40:20]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,
    // tuser = status[2:0]
    output logic [2:0]  m_tuser,
    // arena size register
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [20:0] cfg_data
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    // control registers
    state_t              state_reg, state_next;
    logic [SIZE_W-1:0]   arena_reg, arena_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [SIZE_W-1:0]   free_reg, free_next;
    logic [CNT_W-1:0]    a_reg, a_next;
    logic                pv_reg, pv_next;
    logic                cur_v_reg, cur_v_next;
    logic                m_tvalid_reg, m_tvalid_next;

    // payload registers
    cmd_t                cmd_reg, cmd_next;
    logic [RND_W-1:0]    size_reg, size_next;
    logic [ADDR_W-1:0]   off_reg, off_next;
    logic [CNT_W-1:0]    pi_reg, pi_next;
    logic [IDX_W-1:0]    k_reg, k_next;
    logic [IDX_W-1:0]    w_reg, w_next;
    entry_t              ent_reg, ent_next;
    entry_t              cur_reg, cur_next;
    logic                split_reg, split_next;
    status_t             res_status_reg, res_status_next;
    logic [ADDR_W-1:0]   res_grant_reg, res_grant_next;
    status_t             status_out_reg, status_out_next;
    logic [ADDR_W-1:0]   granted_out_reg, granted_out_next;
    logic [SIZE_W-1:0]   free_out_reg, free_out_next;

    // table ram port
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    entry_t              ram_wdata;
    logic [IDX_W-1:0]    ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;
    entry_t              rd_entry;

    // decode helpers
    logic                s_acc;
    logic                cfg_acc;
    logic                out_load;
    cmd_t                in_cmd;
    logic [SIZE_W-1:0]   in_req;
    logic [ADDR_W-1:0]   in_off;
    logic [RND_W-1:0]    in_size;
    logic                size_ok;
    logic                off_ok;
    logic                hit;
    logic                walk_end;
    logic                walk_issue;
    logic                shift_issue;
    logic                split_now;
    logic [ADDR_W-1:0]   used;
    logic [SIZE_W-1:0]   cfg_clamped;
    entry_t              e_mark;

    ffba_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry = entry_t'(ram_rdata);

    // handshakes
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign out_load  = !m_tvalid_reg || m_tready;

    assign in_cmd  = cmd_t'(s_tuser);
    assign in_req  = s_tdata[20:0];
    assign in_off  = s_tdata[40:21];
    assign in_size = ({1'b0, in_req} + RND_W'(ALIGN_BYTES - 1)) & ~RND_W'(ALIGN_BYTES - 1);

    // arena size clamped to its legal range
    always_comb
    begin
        cfg_clamped = cfg_data;
        if (cfg_data < SIZE_W'(ARENA_MIN))
        begin
            cfg_clamped = SIZE_W'(ARENA_MIN);
        end
        else if (cfg_data > SIZE_W'(ARENA_MAX))
        begin
            cfg_clamped = SIZE_W'(ARENA_MAX);
        end
    end

    // table walk compare unit
    assign size_ok    = {2'b00, rd_entry.payload} >= size_reg;
    assign off_ok     = ({1'b0, rd_entry.start} + SIZE_W'(HEADER_BYTES)) == {1'b0, off_reg};
    assign hit        = pv_reg && ((cmd_reg == CMD_ALLOC) ? (rd_entry.is_free && size_ok)
                                                          : off_ok);
    assign walk_end   = (a_reg == count_reg);
    assign walk_issue = (a_reg < count_reg);
    assign shift_issue = (a_reg > CNT_W'(k_reg));
    assign split_now  = ({2'b00, rd_entry.payload} > size_reg + RND_W'(2 * HEADER_BYTES))
                        && (count_reg < CNT_W'(MAX_BLOCKS));
    assign used       = size_reg[ADDR_W-1:0] + ADDR_W'(HEADER_BYTES);

    // entry read during compaction, with the freed block marked
    always_comb
    begin
        e_mark = rd_entry;
        if (pi_reg == CNT_W'(k_reg))
        begin
            e_mark.is_free = 1'b1;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (s_acc)
                begin
                    if ((in_cmd == CMD_ALLOC && in_req == '0)
                        || (in_cmd == CMD_FREE && in_off == '0))
                    begin
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    if (cmd_reg == CMD_ALLOC)
                    begin
                        state_next = split_now ? S_SHIFT : S_GRANT;
                    end
                    else
                    begin
                        state_next = S_COMPACT;
                    end
                end
                else if (walk_end)
                begin
                    state_next = S_RESP;
                end
            end
            S_SHIFT:
            begin
                if (!shift_issue && !pv_reg)
                begin
                    state_next = S_SPLIT;
                end
            end
            S_SPLIT:
            begin
                state_next = S_GRANT;
            end
            S_GRANT:
            begin
                state_next = S_RESP;
            end
            S_COMPACT:
            begin
                if (pv_reg && walk_end)
                begin
                    state_next = S_CEND;
                end
            end
            S_CEND:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
        if (cfg_acc)
        begin
            state_next = S_INIT;
        end
    end

    // datapath and table ram control
    always_comb
    begin
        arena_next       = arena_reg;
        count_next       = count_reg;
        free_next        = free_reg;
        a_next           = a_reg;
        pv_next          = 1'b0;
        pi_next          = a_reg;
        cur_v_next       = cur_v_reg;
        cmd_next         = cmd_reg;
        size_next        = size_reg;
        off_next         = off_reg;
        k_next           = k_reg;
        w_next           = w_reg;
        ent_next         = ent_reg;
        cur_next         = cur_reg;
        split_next       = split_reg;
        res_status_next  = res_status_reg;
        res_grant_next   = res_grant_reg;
        status_out_next  = status_out_reg;
        granted_out_next = granted_out_reg;
        free_out_next    = free_out_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        ram_we           = 1'b0;
        ram_waddr        = '0;
        ram_wdata        = '0;
        ram_raddr        = a_reg[IDX_W-1:0];

        case (state_reg)
            S_INIT:
            begin
                ram_we            = 1'b1;
                ram_waddr         = '0;
                ram_wdata.start   = '0;
                ram_wdata.payload = ADDR_W'(arena_reg - SIZE_W'(HEADER_BYTES));
                ram_wdata.is_free = 1'b1;
                count_next        = CNT_W'(1);
                free_next         = arena_reg - SIZE_W'(HEADER_BYTES);
            end
            S_IDLE:
            begin
                if (s_acc)
                begin
                    cmd_next       = in_cmd;
                    size_next      = in_size;
                    off_next       = in_off;
                    a_next         = '0;
                    res_grant_next = '0;
                    res_status_next = (in_cmd == CMD_ALLOC) ? ST_ZERO : ST_NULL;
                end
            end
            S_SCAN:
            begin
                pv_next = walk_issue;
                a_next  = walk_issue ? a_reg + CNT_W'(1) : a_reg;
                if (hit)
                begin
                    pv_next    = 1'b0;
                    k_next     = pi_reg[IDX_W-1:0];
                    ent_next   = rd_entry;
                    split_next = split_now;
                    if (cmd_reg == CMD_ALLOC)
                    begin
                        a_next = count_reg - CNT_W'(1);
                    end
                    else
                    begin
                        a_next     = '0;
                        w_next     = '0;
                        cur_v_next = 1'b0;
                        if (!rd_entry.is_free)
                        begin
                            free_next = free_reg + {1'b0, rd_entry.payload};
                        end
                    end
                end
                else if (walk_end)
                begin
                    res_status_next = (cmd_reg == CMD_ALLOC) ? ST_NOFIT : ST_UNKNOWN;
                    res_grant_next  = '0;
                end
            end
            S_SHIFT:
            begin
                // move entries above the split point up by one, top first
                pv_next = shift_issue;
                a_next  = shift_issue ? a_reg - CNT_W'(1) : a_reg;
                if (pv_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = IDX_W'(pi_reg + CNT_W'(1));
                    ram_wdata = rd_entry;
                end
            end
            S_SPLIT:
            begin
                ram_we            = 1'b1;
                ram_waddr         = k_reg + IDX_W'(1);
                ram_wdata.start   = ent_reg.start + used;
                ram_wdata.payload = ent_reg.payload - used;
                ram_wdata.is_free = 1'b1;
            end
            S_GRANT:
            begin
                ram_we            = 1'b1;
                ram_waddr         = k_reg;
                ram_wdata.start   = ent_reg.start;
                ram_wdata.payload = split_reg ? size_reg[ADDR_W-1:0] : ent_reg.payload;
                ram_wdata.is_free = 1'b0;
                if (split_reg)
                begin
                    count_next = count_reg + CNT_W'(1);
                    free_next  = free_reg - {1'b0, used};
                end
                else
                begin
                    free_next = free_reg - {1'b0, ent_reg.payload};
                end
                res_status_next = ST_DONE;
                res_grant_next  = ent_reg.start + ADDR_W'(HEADER_BYTES);
            end
            S_COMPACT:
            begin
                // rewrite the table in place, folding runs of free blocks
                pv_next = walk_issue;
                a_next  = walk_issue ? a_reg + CNT_W'(1) : a_reg;
                if (pv_reg)
                begin
                    if (!cur_v_reg)
                    begin
                        cur_next   = e_mark;
                        cur_v_next = 1'b1;
                    end
                    else if (cur_reg.is_free && e_mark.is_free)
                    begin
                        cur_next.payload = cur_reg.payload + ADDR_W'(HEADER_BYTES)
                                           + e_mark.payload;
                        free_next        = free_reg + SIZE_W'(HEADER_BYTES);
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = w_reg;
                        ram_wdata = cur_reg;
                        w_next    = w_reg + IDX_W'(1);
                        cur_next  = e_mark;
                    end
                end
            end
            S_CEND:
            begin
                ram_we          = 1'b1;
                ram_waddr       = w_reg;
                ram_wdata       = cur_reg;
                count_next      = CNT_W'(w_reg) + CNT_W'(1);
                res_status_next = ST_DONE;
                res_grant_next  = '0;
            end
            S_RESP:
            begin
                if (out_load)
                begin
                    status_out_next  = res_status_reg;
                    granted_out_next = res_grant_reg;
                    free_out_next    = free_reg;
                    m_tvalid_next    = 1'b1;
                end
            end
            default:
            begin
                pv_next = 1'b0;
            end
        endcase

        // new arena size: table totals follow at once
        if (cfg_acc)
        begin
            arena_next = cfg_clamped;
            count_next = CNT_W'(1);
            free_next  = cfg_clamped - SIZE_W'(HEADER_BYTES);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            arena_reg    <= SIZE_W'(ARENA_MAX);
            count_reg    <= CNT_W'(1);
            free_reg     <= SIZE_W'(ARENA_MAX - HEADER_BYTES);
            a_reg        <= '0;
            pv_reg       <= 1'b0;
            cur_v_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            arena_reg    <= arena_next;
            count_reg    <= count_next;
            free_reg     <= free_next;
            a_reg        <= a_next;
            pv_reg       <= pv_next;
            cur_v_reg    <= cur_v_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        size_reg        <= size_next;
        off_reg         <= off_next;
        pi_reg          <= pi_next;
        k_reg           <= k_next;
        w_reg           <= w_next;
        ent_reg         <= ent_next;
        cur_reg         <= cur_next;
        split_reg       <= split_next;
        res_status_reg  <= res_status_next;
        res_grant_reg   <= res_grant_next;
        status_out_reg  <= status_out_next;
        granted_out_reg <= granted_out_next;
        free_out_reg    <= free_out_next;
    end

    // outputs
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, free_out_reg, granted_out_reg};
    assign m_tuser  = status_out_reg;

    // checks
    `FFBA_ASSERT(a_count_range, (count_reg != '0) && (count_reg <= CNT_W'(MAX_BLOCKS)), "block count out of range")
    `FFBA_ASSERT(a_free_le_arena, free_reg <= arena_reg, "free bytes exceed arena")
    `FFBA_ASSERT_NEXT(a_busy_after_accept, s_acc && !cfg_acc, !s_tready, "request taken while busy")
    `FFBA_ASSERT(a_grant_only_done, !m_tvalid_reg || status_out_reg == ST_DONE || granted_out_reg == '0, "offset reported on a rejected request")

endmodule

### rtl/core/ffba_ram.sv
`timescale 1ns / 1ps

module ffba_ram #(
    parameter int WIDTH = 41,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
